>>> hw/rtl/qpf_pkg.sv
// Shared types, constants and saturating helpers for the quartic pair force evaluator.
package qpf_pkg;

  localparam int NUM_TYPES_DEF = 8;
  localparam int WORD_BITS     = 48;
  localparam int FRAC_BITS     = 24;
  localparam int FAC_BITS      = 17;
  localparam int FAC_FRAC      = 16;
  localparam int TYPE_BITS     = 3;
  localparam int SLOT_BITS     = 4;
  localparam int SLOT_COUNT    = 9;
  localparam int RSQ_BITS      = 48;
  localparam int RAD_BITS      = RSQ_BITS + FRAC_BITS;
  localparam int ROOT_BITS     = RAD_BITS / 2;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [WORD_BITS+1:0] wide_t;

  localparam word_t WORD_MAX = word_t'({1'b0, {(WORD_BITS-1){1'b1}}});
  localparam word_t WORD_MIN = word_t'({1'b1, {(WORD_BITS-1){1'b0}}});

  typedef enum logic [0:0] {
    FUNC_WRITE = 1'b0,
    FUNC_EVAL  = 1'b1
  } func_e;

  typedef enum logic [SLOT_BITS-1:0] {
    SLOT_R0  = 4'd0,
    SLOT_Q1  = 4'd1,
    SLOT_Q2  = 4'd2,
    SLOT_Q3  = 4'd3,
    SLOT_Q4  = 4'd4,
    SLOT_Q5  = 4'd5,
    SLOT_Q6  = 4'd6,
    SLOT_SHF = 4'd7,
    SLOT_CUT = 4'd8
  } slot_e;

  function automatic wide_t ext(input word_t a);
    return {{2{a[WORD_BITS-1]}}, a};
  endfunction

  // Clamps a value two bits wider than a word into the word range.
  function automatic word_t sat_wide(input wide_t x);
    word_t r;
    if (!x[WORD_BITS+1] && (x[WORD_BITS:WORD_BITS-1] != 2'b00)) begin
      r = WORD_MAX;
    end else if (x[WORD_BITS+1] && (x[WORD_BITS:WORD_BITS-1] != 2'b11)) begin
      r = WORD_MIN;
    end else begin
      r = x[WORD_BITS-1:0];
    end
    return r;
  endfunction

  function automatic word_t sat_add(input word_t a, input word_t b);
    return sat_wide(ext(a) + ext(b));
  endfunction

  function automatic word_t neg_sat(input word_t a);
    return (a == WORD_MIN) ? WORD_MAX : -a;
  endfunction

endpackage

>>> hw/rtl/quartic_pair_force_eval_unit.sv
// Top level of the quartic pair potential force and energy evaluator.
// Path of a request: the square root, the coefficient read, the polynomial stages,
// the division, the factor stages and the output register.
// Throughput: one request per cycle; the whole pipeline advances together and holds
// while a result waits. Reset clears all valid bits; the coefficient table is not cleared.
module quartic_pair_force_eval_unit #(
  parameter int NUM_TYPES = qpf_pkg::NUM_TYPES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // Fields from bit 0: first_type[3], second_type[3], coeff_slot[4], coeff_value[48],
  // dist_squared[48], special_factor[17], zero fill[5].
  input  logic [127:0] s_axis_tdata,
  // Fields from bit 0: func[1].
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // Fields from bit 0: force_scalar[48], energy[48].
  output logic [95:0]  m_axis_tdata,
  // Fields from bit 0: in_range[1].
  output logic         m_axis_tuser
);
  localparam int W          = qpf_pkg::WORD_BITS;
  localparam int RB         = qpf_pkg::ROOT_BITS;
  localparam int PAIR_DEPTH = NUM_TYPES * NUM_TYPES;
  localparam int PAIR_AW    = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
  localparam int NSTG       = 10;

  // Request side band that rides along the square root pipeline. For an evaluate
  // request the value field carries the squared distance, otherwise the coefficient.
  typedef struct packed {
    qpf_pkg::func_e                func;
    logic                          type_ok;
    logic [PAIR_AW-1:0]            addr;
    logic [qpf_pkg::SLOT_BITS-1:0] slot;
    logic [qpf_pkg::FAC_BITS-1:0]  fac;
    qpf_pkg::word_t                value;
  } req_t;

  // Working set of the polynomial stages.
  typedef struct packed {
    logic                         rng;
    logic [qpf_pkg::FAC_BITS-1:0] fac;
    logic [RB-1:0]                den;
    qpf_pkg::word_t               d;
    qpf_pkg::word_t               dd;
    qpf_pkg::word_t               c1;
    qpf_pkg::word_t               c2;
    qpf_pkg::word_t               c3;
    qpf_pkg::word_t               c4;
    qpf_pkg::word_t               c5;
    qpf_pkg::word_t               c6;
    qpf_pkg::word_t               c7;
    qpf_pkg::word_t               s1;
    qpf_pkg::word_t               s4;
    qpf_pkg::word_t               num;
    qpf_pkg::word_t               ep;
  } ctx_t;

  typedef struct packed {
    logic                         rng;
    logic [qpf_pkg::FAC_BITS-1:0] fac;
    qpf_pkg::word_t               ep;
  } dside_t;

  typedef struct packed {
    logic                         rng;
    logic [qpf_pkg::FAC_BITS-1:0] fac;
    qpf_pkg::word_t               f;
    qpf_pkg::word_t               e;
  } fin_t;

  // One enable moves every stage; it drops only while a finished result is refused.
  logic en;
  logic out_v_q;
  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  // Unpack the request.
  logic [qpf_pkg::TYPE_BITS-1:0] first_type, second_type;
  logic [qpf_pkg::RSQ_BITS-1:0]  dist_squared;
  req_t                          req;

  always_comb begin
    first_type   = s_axis_tdata[2:0];
    second_type  = s_axis_tdata[5:3];
    dist_squared = s_axis_tdata[105:58];
    req.func     = qpf_pkg::func_e'(s_axis_tuser);
    req.type_ok  = (int'(first_type) < NUM_TYPES) && (int'(second_type) < NUM_TYPES);
    req.addr     = PAIR_AW'(int'(first_type) * NUM_TYPES + int'(second_type));
    req.slot     = s_axis_tdata[9:6];
    req.fac      = s_axis_tdata[122:106];
    req.value    = (req.func == qpf_pkg::FUNC_EVAL) ? $signed(dist_squared)
                                                    : $signed(s_axis_tdata[57:10]);
  end

  // Square root of the distance comes first so the table is read and written
  // at one point of the pipeline, which keeps writes and reads in request order.
  logic          sq_v;
  logic [RB-1:0] sq_root;
  req_t          sq_side;

  qpf_sqrt #(.SIDE_W($bits(req_t))) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .rsq_i   (dist_squared),
    .side_i  (req),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // One table bank per coefficient slot, so a pair reads all nine words at once.
  logic [W-1:0] coef [qpf_pkg::SLOT_COUNT];

  for (genvar s = 0; s < qpf_pkg::SLOT_COUNT; s++) begin : g_bank
    logic we;
    assign we = en && sq_v && (sq_side.func == qpf_pkg::FUNC_WRITE) && sq_side.type_ok
                && (sq_side.slot == qpf_pkg::SLOT_BITS'(s));
    qpf_ram #(.WIDTH(W), .DEPTH(PAIR_DEPTH)) u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (sq_side.addr),
      .wdata_i (sq_side.value),
      .re_i    (en),
      .raddr_i (sq_side.addr),
      .rdata_o (coef[s])
    );
  end

  // Registers that run beside the table read.
  logic          rv_q;
  logic [RB-1:0] r_root_q;
  req_t          r_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_root_q <= sq_root;
      r_side_q <= sq_side;
    end
  end

  // Polynomial stages.
  logic [NSTG:1]  v_q;
  ctx_t           st_q [1:NSTG];
  ctx_t           nx   [1:NSTG];
  qpf_pkg::word_t m_dd, m_a2, m_a5, m_b3, m_b6, m_num, m_e;
  qpf_pkg::word_t cut;

  always_comb begin
    cut = $signed(coef[qpf_pkg::SLOT_CUT]);

    nx[1]     = st_q[1];
    nx[1].rng = (r_side_q.func == qpf_pkg::FUNC_EVAL) && r_side_q.type_ok
                && !cut[W-1] && (cut != '0)
                && ($unsigned(r_side_q.value) < $unsigned(cut));
    nx[1].fac = r_side_q.fac;
    nx[1].den = r_root_q;
    nx[1].d   = qpf_pkg::sat_wide(qpf_pkg::wide_t'({{(W+2-RB){1'b0}}, r_root_q})
                                  - qpf_pkg::ext($signed(coef[qpf_pkg::SLOT_R0])));
    nx[1].c1  = $signed(coef[qpf_pkg::SLOT_Q1]);
    nx[1].c2  = $signed(coef[qpf_pkg::SLOT_Q2]);
    nx[1].c3  = $signed(coef[qpf_pkg::SLOT_Q3]);
    nx[1].c4  = $signed(coef[qpf_pkg::SLOT_Q4]);
    nx[1].c5  = $signed(coef[qpf_pkg::SLOT_Q5]);
    nx[1].c6  = $signed(coef[qpf_pkg::SLOT_Q6]);
    nx[1].c7  = $signed(coef[qpf_pkg::SLOT_SHF]);

    nx[2] = st_q[1];
    nx[3] = st_q[2];

    // Linear terms join the constant terms once d squared is known.
    nx[4]    = st_q[3];
    nx[4].dd = m_dd;
    nx[4].s1 = qpf_pkg::sat_add(st_q[3].c1, m_a2);
    nx[4].s4 = qpf_pkg::sat_add(st_q[3].c4, m_a5);

    nx[5] = st_q[4];
    nx[6] = st_q[5];

    // Quadratic terms complete both polynomials.
    nx[7]    = st_q[6];
    nx[7].s1 = qpf_pkg::sat_add(st_q[6].s1, m_b3);
    nx[7].s4 = qpf_pkg::sat_add(st_q[6].s4, m_b6);

    nx[8] = st_q[7];
    nx[9] = st_q[8];

    // Force numerator and the shifted energy before the special-bond factor.
    nx[10]     = st_q[9];
    nx[10].num = m_num;
    nx[10].ep  = qpf_pkg::sat_add(m_e, st_q[9].c7);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
      v_q  <= '0;
    end else if (en) begin
      rv_q <= sq_v;
      v_q  <= {v_q[NSTG-1:1], rv_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q <= nx;
    end
  end

  qpf_mul #(.SH(qpf_pkg::FRAC_BITS)) u_mul_dd (
    .clk_i(clk_i), .en_i(en), .a_i(st_q[1].d), .b_i(st_q[1].d), .y_o(m_dd));
  qpf_mul #(.SH(qpf_pkg::FRAC_BITS)) u_mul_a2 (
    .clk_i(clk_i), .en_i(en), .a_i(st_q[1].c2), .b_i(st_q[1].d), .y_o(m_a2));
  qpf_mul #(.SH(qpf_pkg::FRAC_BITS)) u_mul_a5 (
    .clk_i(clk_i), .en_i(en), .a_i(st_q[1].c5), .b_i(st_q[1].d), .y_o(m_a5));
  qpf_mul #(.SH(qpf_pkg::FRAC_BITS)) u_mul_b3 (
    .clk_i(clk_i), .en_i(en), .a_i(st_q[4].c3), .b_i(st_q[4].dd), .y_o(m_b3));
  qpf_mul #(.SH(qpf_pkg::FRAC_BITS)) u_mul_b6 (
    .clk_i(clk_i), .en_i(en), .a_i(st_q[4].c6), .b_i(st_q[4].dd), .y_o(m_b6));
  qpf_mul #(.SH(qpf_pkg::FRAC_BITS)) u_mul_num (
    .clk_i(clk_i), .en_i(en), .a_i(st_q[7].d), .b_i(st_q[7].s1), .y_o(m_num));
  qpf_mul #(.SH(qpf_pkg::FRAC_BITS)) u_mul_e (
    .clk_i(clk_i), .en_i(en), .a_i(st_q[7].dd), .b_i(st_q[7].s4), .y_o(m_e));

  // Division of the numerator by the distance.
  dside_t         dv_in, dv_out;
  logic           dv_v;
  qpf_pkg::word_t dv_q;

  always_comb begin
    dv_in.rng = st_q[NSTG].rng;
    dv_in.fac = st_q[NSTG].fac;
    dv_in.ep  = st_q[NSTG].ep;
  end

  qpf_div #(.SIDE_W($bits(dside_t))) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_q[NSTG]),
    .num_i   (st_q[NSTG].num),
    .den_i   (st_q[NSTG].den),
    .side_i  (dv_in),
    .valid_o (dv_v),
    .quot_o  (dv_q),
    .side_o  (dv_out)
  );

  // Sign flip of the quotient, then both results take the special-bond factor.
  logic           f11_v_q, f12_v_q, f13_v_q;
  fin_t           f11_q, f12_q, f13_q;
  qpf_pkg::word_t fac_w, m_force, m_energy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f11_v_q <= 1'b0;
      f12_v_q <= 1'b0;
      f13_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      f11_v_q <= dv_v;
      f12_v_q <= f11_v_q;
      f13_v_q <= f12_v_q;
      out_v_q <= f13_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f11_q.rng <= dv_out.rng;
      f11_q.fac <= dv_out.fac;
      f11_q.f   <= qpf_pkg::neg_sat(dv_q);
      f11_q.e   <= dv_out.ep;
      f12_q     <= f11_q;
      f13_q     <= f12_q;
    end
  end

  assign fac_w = $signed({{(W-qpf_pkg::FAC_BITS){1'b0}}, f11_q.fac});

  qpf_mul #(.SH(qpf_pkg::FAC_FRAC)) u_mul_fforce (
    .clk_i(clk_i), .en_i(en), .a_i(f11_q.f), .b_i(fac_w), .y_o(m_force));
  qpf_mul #(.SH(qpf_pkg::FAC_FRAC)) u_mul_fenergy (
    .clk_i(clk_i), .en_i(en), .a_i(f11_q.e), .b_i(fac_w), .y_o(m_energy));

  // Output register: requests outside the cutoff, and table writes, report zeros.
  qpf_pkg::word_t force_q, energy_q;
  logic           rng_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rng_q    <= f13_q.rng;
      force_q  <= f13_q.rng ? m_force : '0;
      energy_q <= f13_q.rng ? m_energy : '0;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {energy_q, force_q};
  assign m_axis_tuser  = rng_q;
endmodule

>>> hw/rtl/qpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module qpf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [WIDTH-1:0]      wdata_i,
  input  logic                  re_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [WIDTH-1:0]      rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

>>> hw/rtl/qpf_sqrt.sv
// Pipelined integer square root, one result bit per stage, with side data.
module qpf_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [qpf_pkg::RSQ_BITS-1:0]   rsq_i,
  input  logic [SIDE_W-1:0]              side_i,
  output logic                           valid_o,
  output logic [qpf_pkg::ROOT_BITS-1:0]  root_o,
  output logic [SIDE_W-1:0]              side_o
);
  localparam int STEPS = qpf_pkg::ROOT_BITS;
  localparam int RAD_W = qpf_pkg::RAD_BITS;
  localparam int REM_W = STEPS + 1;

  logic [STEPS:0]   vld_q;
  logic [RAD_W-1:0] rad_q  [STEPS+1];
  logic [REM_W-1:0] rem_q  [STEPS+1];
  logic [STEPS-1:0] root_q [STEPS+1];
  logic [SIDE_W-1:0] side_q [STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STEPS-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q[0]  <= {rsq_i, {qpf_pkg::FRAC_BITS{1'b0}}};
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    logic             ge;

    always_comb begin
      cur   = {rem_q[k], rad_q[k][RAD_W-1 -: 2]};
      trial = {1'b0, root_q[k], 2'b01};
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k+1]  <= rad_q[k] << 2;
        side_q[k+1] <= side_q[k];
        if (ge) begin
          rem_q[k+1]  <= REM_W'(cur - trial);
          root_q[k+1] <= {root_q[k][STEPS-2:0], 1'b1};
        end else begin
          rem_q[k+1]  <= REM_W'(cur);
          root_q[k+1] <= {root_q[k][STEPS-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld_q[STEPS];
  assign root_o  = root_q[STEPS];
  assign side_o  = side_q[STEPS];
endmodule

>>> hw/rtl/qpf_mul.sv
// Two-stage saturating fixed-point multiplier built from four half-width products.
module qpf_mul #(
  parameter int SH = 24
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  qpf_pkg::word_t a_i,
  input  qpf_pkg::word_t b_i,
  output qpf_pkg::word_t y_o
);
  localparam int W  = qpf_pkg::WORD_BITS;
  localparam int H  = W / 2;
  localparam int PW = 2 * W;

  logic [W-1:0]  mag_a;
  logic [W-1:0]  mag_b;
  logic          neg_q;
  logic [W-1:0]  p00_q, p01_q, p10_q, p11_q;
  logic [PW-1:0] full;
  logic [PW-1:0] shf;
  logic          over;
  qpf_pkg::word_t y_d, y_q;

  always_comb begin
    mag_a = a_i[W-1] ? $unsigned(-a_i) : $unsigned(a_i);
    mag_b = b_i[W-1] ? $unsigned(-b_i) : $unsigned(b_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q <= a_i[W-1] ^ b_i[W-1];
      p00_q <= mag_a[H-1:0] * mag_b[H-1:0];
      p01_q <= mag_a[H-1:0] * mag_b[W-1:H];
      p10_q <= mag_a[W-1:H] * mag_b[H-1:0];
      p11_q <= mag_a[W-1:H] * mag_b[W-1:H];
    end
  end

  always_comb begin
    full = {p11_q, {W{1'b0}}}
         + ({{W{1'b0}}, p01_q} << H)
         + ({{W{1'b0}}, p10_q} << H)
         + {{W{1'b0}}, p00_q};
    shf  = full >> SH;
    if (neg_q) begin
      over = (|shf[PW-1:W]) || (shf[W-1] && (|shf[W-2:0]));
      y_d  = over ? qpf_pkg::WORD_MIN : -$signed(shf[W-1:0]);
    end else begin
      over = |shf[PW-1:W-1];
      y_d  = over ? qpf_pkg::WORD_MAX : $signed(shf[W-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;
endmodule

>>> hw/rtl/qpf_div.sv
// Pipelined restoring divider for the force quotient, one quotient bit per stage.
module qpf_div #(
  parameter int SIDE_W = 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  qpf_pkg::word_t                 num_i,
  input  logic [qpf_pkg::ROOT_BITS-1:0]  den_i,
  input  logic [SIDE_W-1:0]              side_i,
  output logic                           valid_o,
  output qpf_pkg::word_t                 quot_o,
  output logic [SIDE_W-1:0]              side_o
);
  localparam int W     = qpf_pkg::WORD_BITS;
  localparam int F     = qpf_pkg::FRAC_BITS;
  localparam int DW    = qpf_pkg::ROOT_BITS;
  localparam int STEPS = W;

  logic [STEPS:0]    vld_q;
  logic [STEPS:0]    neg_q, zero_q, ovf_q;
  logic [DW-1:0]     rem_q  [STEPS+1];
  logic [DW-1:0]     den_q  [STEPS+1];
  logic [W-1:0]      bits_q [STEPS+1];
  logic [W-1:0]      quo_q  [STEPS+1];
  logic [SIDE_W-1:0] side_q [STEPS+1];

  logic [W-1:0]  mag;
  logic [DW-1:0] hi;

  always_comb begin
    mag = num_i[W-1] ? $unsigned(-num_i) : $unsigned(num_i);
    hi  = DW'(mag[W-1:W-F]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STEPS-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q[0]  <= num_i[W-1];
      zero_q[0] <= (mag == '0);
      ovf_q[0]  <= (hi >= den_i);
      rem_q[0]  <= hi;
      den_q[0]  <= den_i;
      bits_q[0] <= {mag[W-F-1:0], {F{1'b0}}};
      quo_q[0]  <= '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [DW:0] cur;
    logic        ge;

    always_comb begin
      cur = {rem_q[k], bits_q[k][W-1]};
      ge  = (cur >= {1'b0, den_q[k]});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[k+1]  <= neg_q[k];
        zero_q[k+1] <= zero_q[k];
        ovf_q[k+1]  <= ovf_q[k];
        den_q[k+1]  <= den_q[k];
        bits_q[k+1] <= bits_q[k] << 1;
        quo_q[k+1]  <= {quo_q[k][W-2:0], ge};
        side_q[k+1] <= side_q[k];
        rem_q[k+1]  <= ge ? DW'(cur - {1'b0, den_q[k]}) : DW'(cur);
      end
    end
  end

  logic [W-1:0] q;

  always_comb begin
    q = quo_q[STEPS];
    if (zero_q[STEPS]) begin
      quot_o = '0;
    end else if (ovf_q[STEPS]) begin
      quot_o = neg_q[STEPS] ? qpf_pkg::WORD_MIN : qpf_pkg::WORD_MAX;
    end else if (neg_q[STEPS]) begin
      quot_o = (q[W-1] && (|q[W-2:0])) ? qpf_pkg::WORD_MIN : -$signed(q);
    end else begin
      quot_o = q[W-1] ? qpf_pkg::WORD_MAX : $signed(q);
    end
  end

  assign valid_o = vld_q[STEPS];
  assign side_o  = side_q[STEPS];
endmodule

>>> hw/rtl/qpf_checker.sv
// Port-level checks for the quartic pair force evaluator and their binding.
module qpf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  // A result held back must not change.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A result outside the cutoff carries zero force and energy.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("out of range result not zero");

  // The input side stalls exactly when a result is refused.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  // No result is shown during reset.
  a_reset: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");
endmodule

bind quartic_pair_force_eval_unit qpf_checker u_qpf_checker (.*);

>>> tb/tb.sv
// Self-checking testbench for the quartic pair force and energy evaluator.
module tb;

  localparam int NTYPES = 8;
  localparam int TABLE_WORDS = NTYPES * NTYPES * qpf_pkg::SLOT_COUNT;
  localparam int RANDOM_ITEMS = 900;
  localparam int DRAIN_CYCLES = 120;
  localparam longint SAT_POS = 64'sh7FFF_FFFF_FFFF;
  localparam longint ONE_FX = 64'sh100_0000;

  typedef struct {
    logic [47:0] force_scalar;
    logic [47:0] energy;
    logic        in_range;
  } pair_result_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_valid;
  logic [127:0] s_data;
  logic         s_user;
  logic         m_ready;
  logic         s_axis_tready;
  logic         m_axis_tvalid;
  logic [95:0]  m_axis_tdata;
  logic         m_axis_tuser;

  pair_result_t pending_results[$];
  longint       coeff_table[TABLE_WORDS];
  bit           coeff_written[TABLE_WORDS];
  int           ready_pairs[$];
  int           error_count;
  int           mismatch_count;
  int           sent_count;
  int           hold_off_cycles;

  quartic_pair_force_eval_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_data),
    .s_axis_tuser (s_user),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Fixed-point helpers of the predictor, all on exact wide magnitudes.
  function automatic logic [127:0] mag_of(input longint a);
    return (a < 0) ? 128'(-a) : 128'(a);
  endfunction

  function automatic longint clamp_word(input logic neg, input logic [127:0] m);
    logic [127:0] lim;
    lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
    if (m > lim) m = lim;
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic longint fx_sum(input longint a, input longint b);
    longint s;
    s = a + b;
    return clamp_word(s < 0, mag_of(s));
  endfunction

  function automatic longint fx_prod(input longint a, input longint b, input int sh);
    return clamp_word((a < 0) != (b < 0), (mag_of(a) * mag_of(b)) >> sh);
  endfunction

  function automatic longint fx_quot(input longint num, input longint den);
    if (den == 0) return (num == 0) ? 0 : clamp_word(num < 0, 128'h1_0000_0000_0000_0000);
    return clamp_word(num < 0, (mag_of(num) << qpf_pkg::FRAC_BITS) / 128'(den));
  endfunction

  function automatic longint floor_root(input logic [47:0] rsq);
    logic [127:0] radicand;
    logic [127:0] res;
    logic [127:0] cand;
    radicand = 128'(rsq) << qpf_pkg::FRAC_BITS;
    res = '0;
    for (int b = 35; b >= 0; b--) begin
      cand = res | (128'd1 << b);
      if (cand * cand <= radicand) res = cand;
    end
    return longint'(res[63:0]);
  endfunction

  // Applies one request to the predicted table and returns its result.
  function automatic pair_result_t predict_pair_result(input logic func, input int t1,
      input int t2, input int slot, input logic [47:0] value, input logic [47:0] rsq,
      input logic [16:0] factor);
    pair_result_t res;
    int base;
    longint cut, r, d, dd, poly, num, frc, nrg, fac;
    res = '{default: '0};
    base = (t1 * NTYPES + t2) * qpf_pkg::SLOT_COUNT;
    if (func == qpf_pkg::FUNC_WRITE) begin
      if (slot < qpf_pkg::SLOT_COUNT) begin
        coeff_table[base + slot] = {{16{value[47]}}, value};
        coeff_written[base + slot] = 1'b1;
      end
      return res;
    end
    cut = coeff_table[base + qpf_pkg::SLOT_CUT];
    if (cut <= 0 || longint'(rsq) >= cut) return res;
    fac = longint'(factor);
    r = floor_root(rsq);
    d = fx_sum(r, -coeff_table[base + qpf_pkg::SLOT_R0]);
    dd = fx_prod(d, d, qpf_pkg::FRAC_BITS);
    poly = fx_sum(fx_sum(coeff_table[base + qpf_pkg::SLOT_Q1],
                         fx_prod(coeff_table[base + qpf_pkg::SLOT_Q2], d,
                                 qpf_pkg::FRAC_BITS)),
                  fx_prod(coeff_table[base + qpf_pkg::SLOT_Q3], dd, qpf_pkg::FRAC_BITS));
    num = fx_prod(d, poly, qpf_pkg::FRAC_BITS);
    frc = fx_sum(0, -fx_quot(num, r));
    frc = fx_prod(frc, fac, qpf_pkg::FAC_FRAC);
    poly = fx_sum(fx_sum(coeff_table[base + qpf_pkg::SLOT_Q4],
                         fx_prod(coeff_table[base + qpf_pkg::SLOT_Q5], d,
                                 qpf_pkg::FRAC_BITS)),
                  fx_prod(coeff_table[base + qpf_pkg::SLOT_Q6], dd, qpf_pkg::FRAC_BITS));
    nrg = fx_sum(fx_prod(dd, poly, qpf_pkg::FRAC_BITS), coeff_table[base + qpf_pkg::SLOT_SHF]);
    nrg = fx_prod(nrg, fac, qpf_pkg::FAC_FRAC);
    res.force_scalar = frc[47:0];
    res.energy = nrg[47:0];
    res.in_range = 1'b1;
    return res;
  endfunction

  // Offers one request after a random gap and returns once it is accepted.
  task automatic send_request(input logic func, input int t1, input int t2, input int slot,
      input logic [47:0] value, input logic [47:0] rsq, input logic [16:0] factor);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pending_results.push_back(predict_pair_result(func, t1, t2, slot, value, rsq, factor));
    if (func == qpf_pkg::FUNC_WRITE && slot == qpf_pkg::SLOT_CUT) begin
      if (!(t1 * NTYPES + t2 inside {ready_pairs})) begin
        bit full;
        full = 1'b1;
        for (int s = 0; s < qpf_pkg::SLOT_COUNT; s++)
          if (!coeff_written[(t1 * NTYPES + t2) * qpf_pkg::SLOT_COUNT + s]) full = 1'b0;
        if (full) ready_pairs.push_back(t1 * NTYPES + t2);
      end
    end
    s_valid <= 1'b1;
    s_user <= func;
    s_data <= {5'b0, factor, rsq, value, 4'(slot), 3'(t2), 3'(t1)};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_count++;
  endtask

  function automatic logic [47:0] pick_coeff(input int slot, input bit wild);
    int pick;
    pick = $urandom_range(0, 99);
    if (wild) return 48'({$urandom(), $urandom()});
    case (qpf_pkg::slot_e'(slot))
      qpf_pkg::SLOT_R0:  return 48'($urandom_range(32'h80_0000, 32'h280_0000));
      qpf_pkg::SLOT_CUT: begin
        if (pick < 8) return '0;
        if (pick < 13) return -48'($urandom_range(1, 32'h7FFF_FFFF));
        return 48'($urandom_range(1, 16)) << qpf_pkg::FRAC_BITS
               | 48'($urandom_range(0, 32'hFF_FFFF));
      end
      default:  return 48'(longint'($urandom_range(0, 32'h800_0000)) - 64'sh400_0000);
    endcase
  endfunction

  task automatic program_pair(input int t1, input int t2, input bit wild);
    // The cutoff slot goes last so that a pair is only evaluated once complete.
    for (int s = 0; s < qpf_pkg::SLOT_COUNT; s++)
      send_request(qpf_pkg::FUNC_WRITE, t1, t2, s,
                   pick_coeff(s, wild && s != qpf_pkg::SLOT_CUT), '0, '0);
  endtask

  task automatic eval_random_pair();
    int key, pick;
    longint cut;
    logic [47:0] rsq;
    logic [16:0] factor;
    key = ready_pairs[$urandom_range(0, ready_pairs.size() - 1)];
    cut = coeff_table[key * qpf_pkg::SLOT_COUNT + qpf_pkg::SLOT_CUT];
    pick = $urandom_range(0, 99);
    if (pick < 70 && cut > 0) rsq = 48'(longint'({$urandom(), $urandom()} & 64'h7FFF_FFFF_FFFF_FFFF)
                                         % (cut + cut / 8 + 1));
    else if (pick < 85) rsq = 48'($urandom_range(0, 32'hFFFF));
    else rsq = 48'({$urandom(), $urandom()});
    pick = $urandom_range(0, 9);
    factor = (pick < 5) ? 17'd65536 : (pick < 9) ? 17'($urandom_range(0, 65536)) : 17'd0;
    send_request(qpf_pkg::FUNC_EVAL, key / NTYPES, key % NTYPES, $urandom_range(0, 15),
                 48'({$urandom(), $urandom()}), rsq, factor);
  endtask

  task automatic test_directed_cases();
    longint cut;
    // A nominal pair and a pair made of extreme words.
    program_pair(1, 2, 1'b0);
    send_request(qpf_pkg::FUNC_WRITE, 0, 0, qpf_pkg::SLOT_R0, 48'h7FFF_FFFF_FFFF, '0, '0);
    for (int s = qpf_pkg::SLOT_Q1; s <= qpf_pkg::SLOT_SHF; s++)
      send_request(qpf_pkg::FUNC_WRITE, 0, 0, s,
                   (s % 2) ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF, '0, '0);
    send_request(qpf_pkg::FUNC_WRITE, 0, 0, qpf_pkg::SLOT_CUT, 48'h7FFF_FFFF_FFFF, '0, '0);
    // A slot above the table is ignored.
    send_request(qpf_pkg::FUNC_WRITE, 0, 0, 15, 48'hFFFF_FFFF_FFFF, '0, '0);
    cut = coeff_table[(1 * NTYPES + 2) * qpf_pkg::SLOT_COUNT + qpf_pkg::SLOT_CUT];
    if (cut <= 0) begin
      send_request(qpf_pkg::FUNC_WRITE, 1, 2, qpf_pkg::SLOT_CUT, 48'(9 * ONE_FX), '0, '0);
      cut = 9 * ONE_FX;
    end
    // Zero distance, the cutoff edge, factors zero, one and above one.
    send_request(qpf_pkg::FUNC_EVAL, 1, 2, 15, '1, '0, 17'd65536);
    send_request(qpf_pkg::FUNC_EVAL, 1, 2, 0, '0, 48'(cut - 1), 17'd65536);
    send_request(qpf_pkg::FUNC_EVAL, 1, 2, 0, '0, 48'(cut), 17'd65536);
    send_request(qpf_pkg::FUNC_EVAL, 1, 2, 0, '0, 48'(ONE_FX), 17'd0);
    send_request(qpf_pkg::FUNC_EVAL, 1, 2, 0, '0, 48'(ONE_FX / 4), 17'h1FFFF);
    send_request(qpf_pkg::FUNC_EVAL, 0, 0, 0, '0, '1, 17'd65536);
    send_request(qpf_pkg::FUNC_EVAL, 0, 0, 0, '0, 48'(SAT_POS - 1), 17'd65536);
    send_request(qpf_pkg::FUNC_EVAL, 0, 0, 0, '0, 48'd1, 17'd65536);
  endtask

  task automatic test_random_stream();
    int pick;
    while (sent_count < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 6 || ready_pairs.size() == 0) begin
        program_pair($urandom_range(0, NTYPES - 1), $urandom_range(0, NTYPES - 1),
                     $urandom_range(0, 4) == 0);
      end else if (pick < 20) begin
        // Stray coefficient updates, including slots that do not exist.
        send_request(qpf_pkg::FUNC_WRITE, $urandom_range(0, NTYPES - 1),
                     $urandom_range(0, NTYPES - 1), $urandom_range(0, 15),
                     pick_coeff($urandom_range(0, 8), pick < 10),
                     48'({$urandom(), $urandom()}), 17'($urandom()));
      end else begin
        eval_random_pair();
      end
    end
  endtask

  task automatic test_backpressure();
    // The result side stops long enough for the pipeline to fill and stall requests.
    hold_off_cycles = 1500;
    repeat (250) eval_random_pair();
  endtask

  // Result side: random stalls, a long hold when asked, one check per accepted result.
  initial begin
    int stall;
    pair_result_t exp_res;
    @(posedge rst_ni);
    forever begin
      stall = (hold_off_cycles > 0) ? hold_off_cycles : $urandom_range(0, 4);
      hold_off_cycles = 0;
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (pending_results.size() == 0) begin
        error_count++;
        $display("Unexpected result: tdata=%h tuser=%b", m_axis_tdata, m_axis_tuser);
      end else begin
        exp_res = pending_results.pop_front();
        if (m_axis_tdata[47:0] !== exp_res.force_scalar ||
            m_axis_tdata[95:48] !== exp_res.energy || m_axis_tuser !== exp_res.in_range) begin
          error_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: force %h/%h energy %h/%h in_range %b/%b (exp/act)",
                     exp_res.force_scalar, m_axis_tdata[47:0], exp_res.energy,
                     m_axis_tdata[95:48], exp_res.in_range, m_axis_tuser);
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    s_valid = 1'b0;
    s_data = '0;
    s_user = 1'b0;
    m_ready = 1'b0;
    error_count = 0;
    mismatch_count = 0;
    sent_count = 0;
    hold_off_cycles = 0;
    for (int i = 0; i < TABLE_WORDS; i++) begin
      coeff_table[i] = 0;
      coeff_written[i] = 1'b0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_random_stream();
    test_backpressure();
    s_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/qpf_pkg.sv
hw/rtl/qpf_ram.sv
hw/rtl/qpf_sqrt.sv
hw/rtl/qpf_mul.sv
hw/rtl/qpf_div.sv
hw/rtl/quartic_pair_force_eval_unit.sv
hw/rtl/qpf_checker.sv
tb/tb.sv
